/* sv/spc_pkg.sv */
// Shared types and constants for the status packet checker.
package spc_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_CHECK = 2'd0,
    CFG_HEADER_BYTE = 2'd1,
    CFG_MIN_FRAME   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FAIL_NONE     = 3'd0,
    FAIL_SHORT    = 3'd1,
    FAIL_HDR1     = 3'd2,
    FAIL_HDR2     = 3'd3,
    FAIL_LENGTH   = 3'd4,
    FAIL_DEVICE   = 3'd5,
    FAIL_CHECKSUM = 3'd6,
    FAIL_BAD_STEP = 3'd7
  } fail_t;

  localparam int unsigned NumChecks = 6;

  typedef struct packed {
    logic [2:0] first_check;
    logic [7:0] header_byte;
    logic [7:0] min_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic       frame_ok;
    fail_t      fail_reason;
    logic [7:0] device_id;
    logic [7:0] device_error;
  } verdict_t;

endpackage

/* sv/spc_in_if.sv */
// Input byte channel of the status packet checker.
interface spc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

/* sv/spc_out_if.sv */
// Verdict channel of the status packet checker.
interface spc_out_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic [2:0] fail_reason;
  logic [7:0] device_id;
  logic [7:0] device_error;

  modport source (output valid, output frame_ok, output fail_reason,
                  output device_id, output device_error, input ready);
  modport sink   (input valid, input frame_ok, input fail_reason,
                  input device_id, input device_error, output ready);
endinterface

/* sv/spc_cfg_if.sv */
// Configuration write channel of the status packet checker.
interface spc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [spc_pkg::CfgIdxW-1:0] reg_index;
  logic [7:0]                  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* sv/spc_cfg_regs.sv */
// Configuration registers of the status packet checker.
module spc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  spc_cfg_if.sink       cfg_ch,
  output spc_pkg::cfg_t cfg
);

  spc_pkg::cfg_t cfg_r;
  spc_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (spc_pkg::cfg_idx_t'(cfg_ch.reg_index))
        spc_pkg::CFG_FIRST_CHECK: cfg_nxt.first_check     = cfg_ch.wr_data[2:0];
        spc_pkg::CFG_HEADER_BYTE: cfg_nxt.header_byte     = cfg_ch.wr_data;
        spc_pkg::CFG_MIN_FRAME:   cfg_nxt.min_frame_bytes = cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_check     <= 3'd0;
      cfg_r.header_byte     <= 8'd255;
      cfg_r.min_frame_bytes <= 8'd6;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/spc_frame_eval.sv */
// Per-frame state tracking and verdict logic of the status packet checker.
module spc_frame_eval #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  input  spc_pkg::cfg_t     cfg,
  output spc_pkg::verdict_t verdict
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);
  localparam int unsigned NumChecksW = spc_pkg::NumChecks;

  logic [CntW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [1:0]      hdr_mis_r, hdr_mis_nxt;
  logic [7:0]      length_r, length_nxt;
  logic [7:0]      id_r, id_nxt;
  logic [7:0]      error_r, error_nxt;

  logic [CntW-1:0] idx;
  logic [CntW-1:0] n;
  logic [1:0]      hdr_mis_upd;
  logic [7:0]      length_upd, id_upd, error_upd;
  logic [NumChecksW-1:0] fails;
  spc_pkg::fail_t reason;

  assign idx = byte_count_r;
  assign n   = (idx < CntMax) ? CntW'(idx + 1'b1) : CntMax;

  // Fold the current byte into the captured fields before judging.
  always_comb begin
    hdr_mis_upd = hdr_mis_r;
    if (idx == CntW'(0) && rx_byte != cfg.header_byte) hdr_mis_upd[0] = 1'b1;
    if (idx == CntW'(1) && rx_byte != cfg.header_byte) hdr_mis_upd[1] = 1'b1;
    id_upd     = (idx == CntW'(2)) ? rx_byte : id_r;
    length_upd = (idx == CntW'(3)) ? rx_byte : length_r;
    error_upd  = (idx == CntW'(4)) ? rx_byte : error_r;
  end

  always_comb begin
    fails[0] = CmpW'(n) < CmpW'(cfg.min_frame_bytes);
    fails[1] = hdr_mis_upd[0];
    fails[2] = (n < CntW'(2)) || hdr_mis_upd[1];
    fails[3] = (n < CntW'(4)) || (CmpW'(length_upd) != CmpW'(n) - CmpW'(4));
    fails[4] = (n < CntW'(5)) || (error_upd != 8'd0);
    fails[5] = (n < CntW'(3)) || (rx_byte != ~running_sum_r);
  end

  // Report the first failing check at or after the start step; a start step past the last check reports a bad step.
  always_comb begin
    reason = spc_pkg::FAIL_NONE;
    if (cfg.first_check >= 3'(spc_pkg::NumChecks)) begin
      reason = spc_pkg::FAIL_BAD_STEP;
    end else begin
      for (int s = spc_pkg::NumChecks - 1; s >= 0; s--) begin
        if (fails[s] && (3'(s) >= cfg.first_check)) begin
          reason = spc_pkg::fail_t'(3'(s + 1));
        end
      end
    end
  end

  assign verdict.frame_ok     = (reason == spc_pkg::FAIL_NONE);
  assign verdict.fail_reason  = reason;
  assign verdict.device_id    = id_upd;
  assign verdict.device_error = error_upd;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    hdr_mis_nxt     = hdr_mis_r;
    length_nxt      = length_r;
    id_nxt          = id_r;
    error_nxt       = error_r;
    if (step_en) begin
      if (frame_end) begin
        byte_count_nxt  = '0;
        running_sum_nxt = 8'd0;
        hdr_mis_nxt     = 2'b00;
        length_nxt      = 8'd0;
        id_nxt          = 8'd0;
        error_nxt       = 8'd0;
      end else begin
        byte_count_nxt = n;
        if (idx >= CntW'(2)) running_sum_nxt = running_sum_r + rx_byte;
        hdr_mis_nxt = hdr_mis_upd;
        length_nxt  = length_upd;
        id_nxt      = id_upd;
        error_nxt   = error_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= 8'd0;
      hdr_mis_r     <= 2'b00;
      length_r      <= 8'd0;
      id_r          <= 8'd0;
      error_r       <= 8'd0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      hdr_mis_r     <= hdr_mis_nxt;
      length_r      <= length_nxt;
      id_r          <= id_nxt;
      error_r       <= error_nxt;
    end
  end

endmodule

/* sv/status_packet_checker.sv */
// Top level of the status packet checker: input register, frame logic, verdict register.
//
//   port     dir   handshake      payload
//   in_ch    sink  valid/ready    rx_byte[7:0], frame_end
//   out_ch   src   valid/ready    frame_ok, fail_reason[2:0], device_id[7:0], device_error[7:0]
//   cfg_ch   sink  valid/ready    reg_index[1:0], wr_data[7:0]
//
// One byte is accepted per cycle unless a final byte is held in the input register by a
// stalled verdict; the last byte passes from the input register into the verdict register.
// Synchronous active-low reset clears the frame state, the pipeline valids and
// restores register defaults. A stalled verdict holds only a waiting last byte;
// other bytes keep flowing. cfg_ch is always ready.
module status_packet_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input logic     clk,
  input logic     rst_n,
  spc_in_if.sink  in_ch,
  spc_out_if.source out_ch,
  spc_cfg_if.sink cfg_ch
);

  spc_pkg::cfg_t     cfg;
  spc_pkg::verdict_t verdict;

  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_adv;
  logic       out_free;

  logic              out_vld_r, out_vld_nxt;
  spc_pkg::verdict_t out_r;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && (!s1_end_r || out_free);
  assign in_ch.ready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_ch.valid && in_ch.ready) s1_vld_nxt = 1'b1;
    else if (s1_adv)                s1_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv && s1_end_r) out_vld_nxt = 1'b1;
    else if (out_ch.ready)  out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_end_r  <= in_ch.frame_end;
    end
    if (s1_adv && s1_end_r) begin
      out_r <= verdict;
    end
  end

  spc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  spc_frame_eval #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .rx_byte   (s1_byte_r),
    .frame_end (s1_end_r),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.frame_ok     = out_r.frame_ok;
  assign out_ch.fail_reason  = 3'(out_r.fail_reason);
  assign out_ch.device_id    = out_r.device_id;
  assign out_ch.device_error = out_r.device_error;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("pipeline valid set after reset");

  a_mid_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_end_r |-> s1_adv)
    else $error("non-final byte stalled in input register");

  a_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_end_r && out_vld_r && !out_ch.ready |=> s1_vld_r && s1_end_r)
    else $error("final byte lost while verdict stalled");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.frame_ok == (out_r.fail_reason == spc_pkg::FAIL_NONE)))
    else $error("frame_ok disagrees with fail_reason");

endmodule

/* verif/status_packet_checker_test.sv */
// Self-checking testbench for the status packet checker: frame stimulus, verdict predictor.
module status_packet_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFrame = 256;
  localparam int unsigned IdlePct  = 27;
  localparam int unsigned Drain    = 4;

  // check steps in the order the block applies them
  localparam int StepMinLen   = 0;
  localparam int StepHeader1  = 1;
  localparam int StepHeader2  = 2;
  localparam int StepLength   = 3;
  localparam int StepDevError = 4;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic [7:0]        in_byte = 8'h00;
  logic              in_end = 1'b0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  spc_pkg::cfg_idx_t cfg_index = spc_pkg::CFG_FIRST_CHECK;
  logic [7:0]        cfg_data = 8'h00;

  spc_in_if  in_bus ();
  spc_out_if out_bus ();
  spc_cfg_if cfg_bus ();

  assign in_bus.valid      = in_valid;
  assign in_bus.rx_byte    = in_byte;
  assign in_bus.frame_end  = in_end;
  assign out_bus.ready     = out_ready;
  assign cfg_bus.valid     = cfg_valid;
  assign cfg_bus.reg_index = cfg_index;
  assign cfg_bus.wr_data   = cfg_data;

  status_packet_checker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rx_item_t          rx_pending[$];
  spc_pkg::verdict_t verdicts_due[$];
  int unsigned       bytes_queued = 0;
  int unsigned       bytes_taken = 0;
  int unsigned       mismatches = 0;
  bit                steady = 1'b0;

  // predictor copy of the registers and the frame in progress
  spc_pkg::cfg_t model_cfg = '{first_check: 3'd0, header_byte: 8'hFF, min_frame_bytes: 8'd6};
  logic [8:0] rx_count = '0;
  logic [7:0] rx_sum = '0;
  logic [1:0] hdr_miss = '0;
  logic [7:0] len_byte = '0;
  logic [7:0] id_byte = '0;
  logic [7:0] err_byte = '0;

  function automatic spc_pkg::fail_t judge_frame(int unsigned n, logic [7:0] last);
    spc_pkg::fail_t why;
    why = spc_pkg::FAIL_NONE;
    if (model_cfg.first_check >= spc_pkg::NumChecks) return spc_pkg::FAIL_BAD_STEP;
    for (int s = model_cfg.first_check;
         s < spc_pkg::NumChecks && why == spc_pkg::FAIL_NONE; s++) begin
      case (s)
        StepMinLen: if (n < model_cfg.min_frame_bytes) why = spc_pkg::FAIL_SHORT;
        StepHeader1: if (n < 1 || hdr_miss[0]) why = spc_pkg::FAIL_HDR1;
        StepHeader2: if (n < 2 || hdr_miss[1]) why = spc_pkg::FAIL_HDR2;
        StepLength: if (n < 4 || len_byte != n - 4) why = spc_pkg::FAIL_LENGTH;
        StepDevError: if (n < 5 || err_byte != 8'h00) why = spc_pkg::FAIL_DEVICE;
        default: if (n < 3 || last != 8'(8'd255 - rx_sum)) why = spc_pkg::FAIL_CHECKSUM;
      endcase
    end
    return why;
  endfunction

  task automatic absorb_byte(logic [7:0] rx, logic last);
    int unsigned       idx;
    int unsigned       n;
    spc_pkg::fail_t    why;
    spc_pkg::verdict_t v;
    idx = rx_count;
    n = (idx < MaxFrame) ? idx + 1 : MaxFrame;
    if (idx == 0 && rx != model_cfg.header_byte) hdr_miss[0] = 1'b1;
    if (idx == 1 && rx != model_cfg.header_byte) hdr_miss[1] = 1'b1;
    if (idx == 2) id_byte = rx;
    if (idx == 3) len_byte = rx;
    if (idx == 4) err_byte = rx;
    if (!last) begin
      if (idx >= 2) rx_sum = rx_sum + rx;
      rx_count = 9'(n);
    end else begin
      why = judge_frame(n, rx);
      v.frame_ok = (why == spc_pkg::FAIL_NONE);
      v.fail_reason = why;
      v.device_id = id_byte;
      v.device_error = err_byte;
      verdicts_due = {verdicts_due, v};
      rx_count = '0;
      rx_sum = '0;
      hdr_miss = '0;
      len_byte = '0;
      id_byte = '0;
      err_byte = '0;
    end
  endtask

  // byte sender
  always @(posedge clk) begin : feed
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) begin
        absorb_byte(in_byte, in_end);
        bytes_taken++;
      end
      if (!in_valid || in_bus.ready) begin
        if (rx_pending.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          nxt = rx_pending.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.rx_byte;
          in_end <= nxt.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // verdict receiver and checker
  always @(posedge clk) begin : watch
    spc_pkg::verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none expected: ok=%0d reason=%0d", out_bus.frame_ok,
                 out_bus.fail_reason);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_bus.frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0d, got %0d", want.frame_ok, out_bus.frame_ok);
            mismatches++;
          end
          if (out_bus.fail_reason !== want.fail_reason) begin
            $error("fail_reason: expected %0d, got %0d", want.fail_reason,
                   out_bus.fail_reason);
            mismatches++;
          end
          if (out_bus.device_id !== want.device_id) begin
            $error("device_id: expected %0d, got %0d", want.device_id, out_bus.device_id);
            mismatches++;
          end
          if (out_bus.device_error !== want.device_error) begin
            $error("device_error: expected %0d, got %0d", want.device_error,
                   out_bus.device_error);
            mismatches++;
          end
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= IdlePct;
    end
  end

  task automatic queue_frame(byte_q_t b, bit close);
    rx_item_t it;
    foreach (b[i]) begin
      it.rx_byte = b[i];
      it.frame_end = close && (i == b.size() - 1);
      rx_pending = {rx_pending, it};
    end
    bytes_queued += b.size();
  endtask

  // well-formed frame of n bytes, then damaged now and then
  task automatic queue_random_frame(int unsigned n);
    byte_q_t     b;
    logic [7:0]  sum;
    int unsigned pick;
    int unsigned judged;
    sum = '0;
    judged = (n > MaxFrame) ? MaxFrame : n;
    for (int unsigned i = 0; i < n; i++) begin
      case (i)
        0, 1: b = {b, model_cfg.header_byte};
        3: b = {b, 8'(judged - 4)};
        4: b = {b, 8'h00};
        default: b = {b, 8'($urandom)};
      endcase
    end
    if (n >= 3) begin
      for (int unsigned i = 2; i + 1 < n; i++) sum = sum + b[i];
      b[n-1] = 8'd255 - sum;
    end
    pick = $urandom_range(0, 99);
    if (pick >= 97) begin
      foreach (b[i]) b[i] = 8'($urandom);
    end else if (pick >= 92) begin
      b[n-1] ^= 8'($urandom_range(1, 255));
    end else if (pick >= 85) begin
      b[$urandom_range(0, (n > 1) ? 1 : 0)] ^= 8'($urandom_range(1, 255));
    end else if (pick >= 78) begin
      if (n > 4) b[4] = 8'($urandom_range(1, 255));
    end else if (pick >= 68) begin
      b[$urandom_range(0, n - 1)] = 8'($urandom);
    end
    queue_frame(b, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 5);
    return $urandom_range(6, 14);
  endfunction

  // hold until every byte is taken and every verdict is in, then let the pipe drain
  task automatic settle();
    while (bytes_taken != bytes_queued || verdicts_due.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(spc_pkg::cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_valid <= 1'b0;
    case (idx)
      spc_pkg::CFG_FIRST_CHECK: model_cfg.first_check = val[2:0];
      spc_pkg::CFG_HEADER_BYTE: model_cfg.header_byte = val;
      spc_pkg::CFG_MIN_FRAME: model_cfg.min_frame_bytes = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [2:0] step, logic [7:0] hdr, logic [7:0] min_len);
    write_reg(spc_pkg::CFG_FIRST_CHECK, {5'($urandom), step});
    write_reg(spc_pkg::CFG_HEADER_BYTE, hdr);
    write_reg(spc_pkg::CFG_MIN_FRAME, min_len);
  endtask

  initial begin
    int unsigned goal;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: good frame, one-byte frame, short frame
    queue_frame({8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFE}, 1'b1);
    queue_frame({8'h00}, 1'b1);
    queue_frame({8'hFF, 8'hFF, 8'h07}, 1'b1);
    settle();

    // skip length minimum; second header wrong, then frame too short for length
    set_config(3'd1, 8'hFF, 8'd0);
    queue_frame({8'hFF, 8'h00}, 1'b1);
    queue_frame({8'hFF, 8'hFF, 8'h01}, 1'b1);
    settle();

    // checksum only: empty sum on a three-byte frame
    set_config(3'd5, 8'h00, 8'd6);
    queue_frame({8'h12, 8'h34, 8'hFF}, 1'b1);
    settle();

    // start step past the last check rejects outright
    set_config(3'd6, 8'hFF, 8'd6);
    queue_frame({8'hFF}, 1'b1);
    settle();
    write_reg(spc_pkg::CFG_FIRST_CHECK, 8'd7);
    queue_frame({8'hFF}, 1'b1);
    settle();

    // header value changes between the two header bytes
    set_config(3'd0, 8'hA5, 8'd6);
    queue_frame({8'hA5}, 1'b0);
    settle();
    write_reg(spc_pkg::CFG_HEADER_BYTE, 8'h3C);
    queue_frame({8'h3C, 8'h01, 8'h02, 8'h00, 8'hFC}, 1'b1);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_config(3'd0, 8'hFF, 8'd6);
        1: set_config(3'd0, 8'h00, 8'd0);
        2: set_config(3'd0, 8'($urandom), 8'd255);
        3: set_config(3'd0, 8'($urandom), 8'($urandom_range(1, 8)));
        4: set_config(3'($urandom_range(1, 5)), 8'($urandom), 8'($urandom_range(0, 10)));
        5: set_config(3'd0, 8'hAA, 8'd6);
        6: set_config(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
        default: set_config(3'($urandom_range(0, 2)), 8'($urandom), 8'($urandom_range(1, 9)));
      endcase
      steady = (ph == 3);
      goal = bytes_queued + 80;
      while (bytes_queued < goal) queue_random_frame(pick_length());
      if (ph == 2 || ph == 5) queue_random_frame($urandom_range(MaxFrame - 2, MaxFrame + 40));
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("** status_packet_checker: PASSED **");
    end else begin
      $display("** status_packet_checker: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** status_packet_checker: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
sv/spc_pkg.sv
sv/spc_in_if.sv
sv/spc_out_if.sv
sv/spc_cfg_if.sv
sv/spc_cfg_regs.sv
sv/spc_frame_eval.sv
sv/status_packet_checker.sv
verif/status_packet_checker_test.sv
